/* sv/ppht_pkg.sv */
// Shared types and constants for the polyline pick hit test.
// Used by the controller, the datapath, the multiplier and the top level; depends on nothing.
package ppht_pkg;

  localparam int TOL_WIDTH       = 15;
  localparam int MUL_CHUNK       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 15'd4;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PICK_X    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PICK_Y    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOLERANCE = 2'd2;

  // Products taken on the shared multiplier, in the order they are issued.
  typedef enum logic [2:0] {
    OP_AB,
    OP_CD,
    OP_CROSS,
    OP_SQ1,
    OP_SQ2,
    OP_TT,
    OP_LENTT
  } op_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_start;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic seg;
    logic box_ok;
    logic mul_done;
    logic out_busy;
    logic last;
  } status_t;

endpackage

/* sv/polyline_pick_hit_test.sv */
// Top level of the polyline pick hit test: joins the controller and the datapath.
// Depends on ppht_pkg, ppht_ctrl and ppht_dp.
//
//   Channel   Direction  Transaction
//   s_*       in         one vertex: tdata = vertex_x, vertex_y; tuser = first_vertex;
//                        tlast = last_vertex
//   m_*       out        one result per polyline: tdata bit 0 = hit
//   cfg_*     in         register write: 0 pick_x, 1 pick_y, 2 tolerance
//
// A vertex that opens a polyline, or whose segment misses the widened box, skips the products.
// A segment inside the box takes seven products in turn on one shared iterative multiplier, each
// worked through NCH 16-bit slices of the multiplier operand (3 at COORD_WIDTH = 16).
// Reset is synchronous; no clearing pass is needed. The result sits in an output register,
// so the next vertex is taken while it waits; only a closing vertex stalls behind it.
module polyline_pick_hit_test #(
  parameter int  COORD_WIDTH = 16,
  localparam int SDW  = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFGW = (COORD_WIDTH > ppht_pkg::TOL_WIDTH) ? COORD_WIDTH : ppht_pkg::TOL_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [SDW-1:0]                       s_tdata,  // vertex_x, vertex_y, zero fill
  input  logic                                 s_tuser,  // first_vertex
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,  // hit, zero fill
  input  logic                                 cfg_we,
  input  logic [ppht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFGW-1:0]                      cfg_data
);
  import ppht_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    out_hit;

  ppht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  ppht_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .vertex_x    (s_tdata[COORD_WIDTH-1:0]),
    .vertex_y    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .first_vertex(s_tuser),
    .last_vertex (s_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_hit     (out_hit)
  );

  assign m_tdata = {7'd0, out_hit};

endmodule

/* sv/ppht_mul.sv */
// Iterative unsigned multiplier, one MUL_CHUNK-bit slice of the second operand per cycle.
// Depends on ppht_pkg for the slice width.
module ppht_mul #(
  parameter int  OPW = 34,
  localparam int NCH = (OPW + ppht_pkg::MUL_CHUNK - 1) / ppht_pkg::MUL_CHUNK,
  localparam int AW  = OPW + NCH * ppht_pkg::MUL_CHUNK
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  output logic           done,
  output logic [AW-1:0]  product
);
  import ppht_pkg::*;

  localparam int K    = MUL_CHUNK;
  localparam int BWID = NCH * K;
  localparam int SW   = OPW + K;
  localparam int CW   = $clog2(NCH + 1);

  logic [OPW-1:0]  a_reg;
  logic [BWID-1:0] b_reg;
  logic [AW-1:0]   acc;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [OPW-1:0]  upper;
  logic [SW-1:0]   step_sum;
  logic [AW-1:0]   acc_next;

  // The partial sum enters at the top of the accumulator, which then moves right by one slice.
  assign upper    = acc[AW-1 -: OPW];
  assign step_sum = SW'(upper) + SW'(a_reg) * SW'(b_reg[K-1:0]);
  assign acc_next = {step_sum, acc[AW-OPW-1:K]};
  assign product  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NCH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= BWID'(b);
      acc   <= '0;
    end else if (busy) begin
      acc   <= acc_next;
      b_reg <= b_reg >> K;
    end
  end

endmodule

/* sv/ppht_ctrl.sv */
// Controller for the pick hit test: sequences load, preparation, the products and the finish.
// Depends on ppht_pkg for the command and status structs.
module ppht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppht_pkg::status_t status,
  output ppht_pkg::cmd_t    cmd
);
  import ppht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINAL
  } state_t;

  state_t state;
  op_t    op;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.op        = op;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.prep      = (state == S_PREP);
    cmd.mul_start = (state == S_MUL_GO);
    // A closing vertex must wait for the output register to drain.
    cmd.finish    = (state == S_FINAL) && !(status.last && status.out_busy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_AB;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PREP;
        end
        S_PREP: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          op <= OP_AB;
          if (status.seg && status.box_ok) state <= S_MUL_GO;
          else state <= S_FINAL;
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (status.mul_done) begin
            if (op == OP_LENTT) begin
              state <= S_FINAL;
            end else begin
              op    <= op_t'(op + 3'd1);
              state <= S_MUL_GO;
            end
          end
        end
        S_FINAL: begin
          if (!(status.last && status.out_busy)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/ppht_dp.sv */
// Datapath for the pick hit test: configuration, vertex history, box test, operand
// selection around the shared multiplier, final compare and output register.
// Depends on ppht_pkg and ppht_mul.
module ppht_dp #(
  parameter int  COORD_WIDTH = 16,
  localparam int CFGW = (COORD_WIDTH > ppht_pkg::TOL_WIDTH) ? COORD_WIDTH : ppht_pkg::TOL_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppht_pkg::cmd_t                       cmd,
  output ppht_pkg::status_t                    status,
  input  logic signed [COORD_WIDTH-1:0]        vertex_x,
  input  logic signed [COORD_WIDTH-1:0]        vertex_y,
  input  logic                                 first_vertex,
  input  logic                                 last_vertex,
  input  logic                                 cfg_we,
  input  logic [ppht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFGW-1:0]                      cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_hit
);
  import ppht_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW1 = 2 * W + 1;
  localparam int CRW = 2 * W + 2;
  localparam int TTW = 2 * TOL_WIDTH;
  localparam int MW  = (CRW > TTW) ? CRW : TTW;
  localparam int NCH = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AW  = MW + NCH * MUL_CHUNK;
  localparam int BW  = ((W > TOL_WIDTH) ? W : TOL_WIDTH) + 2;

  // Configuration.
  logic signed [W-1:0]    pick_x;
  logic signed [W-1:0]    pick_y;
  logic [TOL_WIDTH-1:0]   tolerance;

  // Polyline state and the vertex in hand.
  logic signed [W-1:0]    prev_x;
  logic signed [W-1:0]    prev_y;
  logic signed [W-1:0]    cur_x;
  logic signed [W-1:0]    cur_y;
  logic                   cur_first;
  logic                   cur_last;
  logic                   have_prev;
  logic                   hit_so_far;

  // Prepared differences.
  logic [DW-1:0]          mag_a;
  logic [DW-1:0]          mag_b;
  logic [DW-1:0]          mag_c;
  logic [DW-1:0]          mag_d;
  logic                   neg_ab;
  logic                   neg_cd;
  logic                   degen;
  logic                   box_ok;

  // Stored products.
  logic [PW1-1:0]         ab;
  logic [PW1-1:0]         cd;
  logic [PW1-1:0]         sq1;
  logic [PW1-1:0]         sq2;
  logic [TTW-1:0]         tt;
  logic [2*MW-1:0]        cross2;
  logic [2*MW-1:0]        lentt;

  logic signed [DW-1:0]   dif_a;
  logic signed [DW-1:0]   dif_b;
  logic signed [DW-1:0]   dif_c;
  logic signed [DW-1:0]   dif_d;
  logic signed [BW-1:0]   x0e, x1e, y0e, y1e, pxe, pye, te;
  logic signed [BW-1:0]   minx, maxx, miny, maxy;
  logic                   box_ok_c;
  logic [CRW-1:0]         cross_mag;
  logic [CRW-1:0]         len_sum;
  logic [MW-1:0]          op_a;
  logic [MW-1:0]          op_b;
  logic                   mul_done;
  logic [AW-1:0]          product;
  logic                   seg;
  logic                   seg_hit;
  logic                   hit_new;

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    return v[DW-1] ? DW'(n) : DW'(v);
  endfunction

  // Segment from the previous vertex (start) to the current one (end).
  assign dif_a = DW'(pick_x) - DW'(prev_x);
  assign dif_b = DW'(cur_y) - DW'(prev_y);
  assign dif_c = DW'(cur_x) - DW'(prev_x);
  assign dif_d = DW'(pick_y) - DW'(prev_y);

  assign x0e  = BW'(prev_x);
  assign x1e  = BW'(cur_x);
  assign y0e  = BW'(prev_y);
  assign y1e  = BW'(cur_y);
  assign pxe  = BW'(pick_x);
  assign pye  = BW'(pick_y);
  assign te   = BW'(tolerance);
  assign minx = (x0e < x1e) ? x0e : x1e;
  assign maxx = (x0e < x1e) ? x1e : x0e;
  assign miny = (y0e < y1e) ? y0e : y1e;
  assign maxy = (y0e < y1e) ? y1e : y0e;
  assign box_ok_c = (pxe >= minx - te) && (pxe <= maxx + te) &&
                    (pye >= miny - te) && (pye <= maxy + te);

  // Magnitude of the cross product from the two signed partial products.
  always_comb begin
    if (neg_ab != neg_cd) cross_mag = CRW'(ab) + CRW'(cd);
    else if (ab >= cd) cross_mag = CRW'(ab - cd);
    else cross_mag = CRW'(cd - ab);
  end

  assign len_sum = CRW'(sq1) + CRW'(sq2);

  // For a segment of zero length the two squares are taken of the offsets to the pick point.
  always_comb begin
    unique case (cmd.op)
      OP_AB: begin
        op_a = MW'(mag_a);
        op_b = MW'(mag_b);
      end
      OP_CD: begin
        op_a = MW'(mag_c);
        op_b = MW'(mag_d);
      end
      OP_CROSS: begin
        op_a = MW'(cross_mag);
        op_b = MW'(cross_mag);
      end
      OP_SQ1: begin
        op_a = degen ? MW'(mag_a) : MW'(mag_b);
        op_b = op_a;
      end
      OP_SQ2: begin
        op_a = degen ? MW'(mag_d) : MW'(mag_c);
        op_b = op_a;
      end
      OP_TT: begin
        op_a = MW'(tolerance);
        op_b = MW'(tolerance);
      end
      OP_LENTT: begin
        op_a = MW'(len_sum);
        op_b = MW'(tt);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ppht_mul #(
    .OPW(MW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (op_a),
    .b      (op_b),
    .done   (mul_done),
    .product(product)
  );

  assign seg     = have_prev && !cur_first;
  assign seg_hit = box_ok && (degen ? (MW'(len_sum) <= MW'(tt)) : (cross2 <= lentt));
  assign hit_new = seg && (hit_so_far || seg_hit);

  assign status.seg      = seg;
  assign status.box_ok   = box_ok;
  assign status.mul_done = mul_done;
  assign status.out_busy = out_valid && !out_ready;
  assign status.last     = cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_x     <= '0;
      pick_y     <= '0;
      tolerance  <= TOL_RESET;
      have_prev  <= 1'b0;
      hit_so_far <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PICK_X:    pick_x    <= cfg_data[W-1:0];
          CFG_PICK_Y:    pick_y    <= cfg_data[W-1:0];
          CFG_TOLERANCE: tolerance <= cfg_data[TOL_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.finish && cur_last) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish) begin
        if (cur_last) begin
          have_prev  <= 1'b0;
          hit_so_far <= 1'b0;
        end else begin
          have_prev  <= 1'b1;
          hit_so_far <= hit_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x     <= vertex_x;
      cur_y     <= vertex_y;
      cur_first <= first_vertex;
      cur_last  <= last_vertex;
    end
    if (cmd.prep) begin
      mag_a  <= mag_of(dif_a);
      mag_b  <= mag_of(dif_b);
      mag_c  <= mag_of(dif_c);
      mag_d  <= mag_of(dif_d);
      neg_ab <= dif_a[DW-1] ^ dif_b[DW-1];
      neg_cd <= dif_c[DW-1] ^ dif_d[DW-1];
      degen  <= (dif_b == '0) && (dif_c == '0);
      box_ok <= box_ok_c;
    end
    if (mul_done) begin
      unique case (cmd.op)
        OP_AB:    ab     <= product[PW1-1:0];
        OP_CD:    cd     <= product[PW1-1:0];
        OP_CROSS: cross2 <= product[2*MW-1:0];
        OP_SQ1:   sq1    <= product[PW1-1:0];
        OP_SQ2:   sq2    <= product[PW1-1:0];
        OP_TT:    tt     <= product[TTW-1:0];
        OP_LENTT: lentt  <= product[2*MW-1:0];
        default: ;
      endcase
    end
    if (cmd.finish) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      if (cur_last) out_hit <= hit_new;
    end
  end

endmodule

/* bench/ppht_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the polyline pick hit test: follows register writes and vertex transactions,
// predicts the hit flag of every closed polyline and compares each result transaction.
// Depends on ppht_pkg for the register indexes and the tolerance width.
module ppht_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [31:0]                          s_tdata,  // vertex_x, vertex_y
  input  logic                                 s_tuser,  // first_vertex
  input  logic                                 s_tlast,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [7:0]                           m_tdata,  // hit, zero fill
  input  logic                                 cfg_we,
  input  logic [ppht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                          cfg_data,
  output int                                   errors,
  output int                                   pending,
  output int                                   results,
  output int                                   hits
);
  import ppht_pkg::*;

  typedef struct packed {
    logic               last;
    logic               first;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vertex_t;

  logic signed [15:0]   pt_x = '0;
  logic signed [15:0]   pt_y = '0;
  logic [TOL_WIDTH-1:0] pick_tol = TOL_RESET;
  logic signed [15:0]   last_x = '0;
  logic signed [15:0]   last_y = '0;
  logic                 open_line = 1'b0;
  logic                 any_hit = 1'b0;
  bit                   hit_expected[$];
  bit                   want;
  vertex_t              vtx;
  int                   fail_count = 0;
  int                   result_count = 0;
  int                   hit_count = 0;

  // Exact test of one segment against the pick point: widened box first, then
  // cross^2 <= tol^2 * len^2, or plain point distance when both ends coincide.
  function automatic bit segment_picked(longint x0, longint y0, longint x1, longint y1);
    longint       px, py, t, lox, hix, loy, hiy, a, b, c, d, xprod;
    logic [127:0] t2, lhs, rhs, len2, m;
    px  = pt_x;
    py  = pt_y;
    t   = pick_tol;
    lox = (x0 < x1) ? x0 : x1;
    hix = (x0 < x1) ? x1 : x0;
    loy = (y0 < y1) ? y0 : y1;
    hiy = (y0 < y1) ? y1 : y0;
    if (px < lox - t || px > hix + t || py < loy - t || py > hiy + t) return 1'b0;
    t2 = t * t;
    if (x0 == x1 && y0 == y1) begin
      lhs = (px - x0) * (px - x0) + (py - y0) * (py - y0);
      return lhs <= t2;
    end
    a     = px - x0;
    b     = y1 - y0;
    c     = x1 - x0;
    d     = py - y0;
    xprod = a * b - c * d;
    m     = (xprod < 0) ? -xprod : xprod;
    lhs   = m * m;
    len2  = b * b + c * c;
    rhs   = len2 * t2;
    return lhs <= rhs;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pt_x      = '0;
      pt_y      = '0;
      pick_tol  = TOL_RESET;
      last_x    = '0;
      last_y    = '0;
      open_line = 1'b0;
      any_hit   = 1'b0;
      hit_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PICK_X:    pt_x = cfg_data;
          CFG_PICK_Y:    pt_y = cfg_data;
          CFG_TOLERANCE: pick_tol = cfg_data[TOL_WIDTH-1:0];
          default: ;
        endcase
      end
      // Results are compared before this edge's vertex is taken, since a result
      // can never belong to a vertex accepted at the same edge.
      if (m_tvalid && m_tready) begin
        result_count++;
        if (m_tdata[0] === 1'b1) hit_count++;
        if (hit_expected.size() == 0) begin
          $error("hit: result transaction with no polyline outstanding, actual %0b", m_tdata[0]);
          fail_count++;
        end else begin
          want = hit_expected.pop_front();
          if (m_tdata[0] !== want) begin
            $error("hit mismatch: expected %0b, actual %0b", want, m_tdata[0]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        vtx = {s_tlast, s_tuser, s_tdata};
        if (vtx.first || !open_line) any_hit = 1'b0;
        else if (segment_picked(last_x, last_y, vtx.x, vtx.y)) any_hit = 1'b1;
        last_x    = vtx.x;
        last_y    = vtx.y;
        open_line = 1'b1;
        if (vtx.last) begin
          hit_expected.push_back(any_hit);
          open_line = 1'b0;
          any_hit   = 1'b0;
        end
      end
    end
    errors  <= fail_count;
    pending <= hit_expected.size();
    results <= result_count;
    hits    <= hit_count;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Top of the polyline pick hit test bench: clock, reset, vertex and register stimulus,
// result back-pressure and the verdict. Depends on ppht_pkg, ppht_checker and the block.
module tb;
  import ppht_pkg::*;

  localparam int COORD_WIDTH    = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_VERTICES = 110;
  localparam int SETTLE_CYCLES  = 50;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [15:0]         C_MIN     = 16'sh8000;
  localparam logic signed [15:0]         C_MAX     = 16'sh7FFF;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata = '0;  // vertex_x, vertex_y
  logic                       s_tuser = 1'b0;  // first_vertex
  logic                       s_tlast = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;  // hit, zero fill
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_PICK_X;
  logic [15:0]                cfg_data = '0;

  int                 errors, pending, results, hits;
  int                 burst_left = 0;
  int                 vertex_count = 0;
  bit                 hold_req = 1'b0;
  logic signed [15:0] cur_px = '0;
  logic signed [15:0] cur_py = '0;
  logic [14:0]        cur_tol = TOL_RESET;

  always #2 clk = ~clk;

  polyline_pick_hit_test #(.COORD_WIDTH(COORD_WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppht_checker pick_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .results   (results),
    .hits      (hits)
  );

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return C_MAX;
    if (v < -32768) return C_MIN;
    return 16'(v);
  endfunction

  function automatic longint spread(longint r);
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  // The sender offers vertices in bursts; a gap is sometimes long enough to cover
  // a whole multiplier pass.
  task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic first, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 45) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    vertex_count++;
  endtask

  // Four polylines in ten are laid along a line through the pick point, so that hits and
  // near misses are common; the rest are scattered near the point, anywhere, or
  // a single point repeated.
  task automatic send_polyline(input int len, input bit mark_first, input bit close);
    int                 shape, pivot, jit;
    longint             dx, dy, ox, oy, shift_x, shift_y;
    logic signed [15:0] vx, vy;
    shape   = $urandom_range(0, 9);
    jit     = ($urandom_range(0, 1) == 0) ? 0 : ((cur_tol > 1000) ? 1000 : int'(cur_tol)) + 2;
    dx      = ($urandom_range(0, 4) == 0) ? 0 : spread(3000);
    dy      = ($urandom_range(0, 4) == 0) ? 0 : spread(3000);
    pivot   = $urandom_range(0, len);
    shift_x = ($urandom_range(0, 1) == 0) ? 0 : dx / 2;
    shift_y = ($urandom_range(0, 1) == 0) ? 0 : dy / 2;
    ox      = spread(2 * jit + 8);
    oy      = spread(2 * jit + 8);
    for (int i = 0; i < len; i++) begin
      if (shape < 4) begin
        vx = clamp16(cur_px + (i - pivot) * dx + shift_x + spread(jit));
        vy = clamp16(cur_py + (i - pivot) * dy + shift_y + spread(jit));
      end else if (shape < 6) begin
        vx = clamp16(cur_px + spread(2 * jit + 8));
        vy = clamp16(cur_py + spread(2 * jit + 8));
      end else if (shape < 9) begin
        vx = 16'($urandom());
        vy = 16'($urandom());
      end else begin
        vx = clamp16(cur_px + ox);
        vy = clamp16(cur_py + oy);
      end
      send_vertex(vx, vy, mark_first && i == 0, close && i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] tol, input bit touch_spare);
    write_reg(CFG_PICK_X, px);
    write_reg(CFG_PICK_Y, py);
    write_reg(CFG_TOLERANCE, tol);
    if (touch_spare) write_reg(CFG_SPARE, 16'($urandom()));
    cfg_we  <= 1'b0;
    cur_px  = px;
    cur_py  = py;
    cur_tol = tol[14:0];
  endtask

  // A vertex that closes no polyline may still be in the multiplier after the
  // last result has gone, hence the settling cycles.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int left, style;
    logic [31:0] pattern;
    left    = 0;
    style   = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          style   = $urandom_range(0, 3);
          left    = $urandom_range(20, 120);
          pattern = $urandom();
        end
        left--;
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= pattern[left % 32];
          default: m_tready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int r, len, phase_base;
    bit mark_first, close;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed polylines at the reset settings: pick point at the origin, tolerance 4.
    send_vertex(0, 0, 1'b1, 1'b1);
    send_vertex(-10, 0, 1'b1, 1'b0);
    send_vertex(10, 0, 1'b0, 1'b1);
    send_vertex(3, 0, 1'b1, 1'b0);
    send_vertex(3, 0, 1'b0, 1'b1);
    send_vertex(3, 3, 1'b1, 1'b0);
    send_vertex(3, 3, 1'b0, 1'b1);
    send_vertex(10, 0, 1'b1, 1'b0);
    send_vertex(20, 0, 1'b0, 1'b1);
    send_vertex(C_MIN, C_MIN, 1'b1, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0, 1'b1);
    send_vertex(C_MIN, C_MAX, 1'b1, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0, 1'b1);
    // An open polyline abandoned by a fresh first mark.
    send_vertex(C_MAX, C_MAX, 1'b1, 1'b0);
    send_vertex(-100, 5, 1'b1, 1'b0);
    send_vertex(100, 5, 1'b0, 1'b1);
    // No first mark after a closed polyline, and a distance exactly at the tolerance.
    send_vertex(-100, 4, 1'b0, 1'b0);
    send_vertex(100, 4, 1'b0, 1'b1);
    send_vertex(C_MIN, 0, 1'b1, 1'b0);
    send_vertex(C_MIN, 0, 1'b0, 1'b0);
    send_vertex(C_MAX, 0, 1'b0, 1'b1);
    send_vertex(-5, 0, 1'b1, 1'b0);
    send_vertex(5, 0, 1'b0, 1'b0);
    send_vertex(5, 1000, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(C_MIN, C_MAX, 16'd0, 1'b0);
        1: set_config(C_MAX, C_MIN, 16'hFFFF, 1'b1);
        2: set_config(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 300)), 1'b0);
        3: set_config(16'd0, 16'd0, 16'd4, 1'b1);
        4: set_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
        default: set_config(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 40)), 1'b0);
      endcase
      // Short polylines while the receiver holds off, so the output register fills
      // and the closing vertices back up at the input.
      if (p == 2) hold_req = 1'b1;
      phase_base = vertex_count;
      while (vertex_count - phase_base < PHASE_VERTICES) begin
        r          = $urandom_range(0, 99);
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        if (p == 2) len = $urandom_range(1, 3);
        close      = (r >= 8);
        mark_first = !(r >= 8 && r < 16);
        send_polyline(len, mark_first, close);
      end
      send_polyline(2, 1'b1, 1'b1);
      wait_idle();
    end

    $display("Covered %0d vertices over seven register settings, with a %0d-cycle result hold.",
             vertex_count, HOLD_CYCLES);
    $display("Checked %0d polyline results, %0d of them hits.", results, hits);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
